>>> rtl/core/dvc_pkg.sv
// Shared constants, types and helper functions of the distinct value counter.
package dvc_pkg;

  localparam int EXACT_SET_DEPTH = 256;
  localparam int FILTER_BITS     = 4096;

  localparam int VALUE_W     = 64;
  localparam int EST_W       = 13;
  localparam int EXACT_AW    = $clog2(EXACT_SET_DEPTH);
  localparam int FILL_W      = $clog2(EXACT_SET_DEPTH + 1);
  localparam int ROW_W       = 64;
  localparam int FILTER_ROWS = FILTER_BITS / ROW_W;
  localparam int BIT_AW      = $clog2(ROW_W);
  localparam int FILT_AW     = $clog2(FILTER_BITS);
  localparam int ROW_AW      = FILT_AW - BIT_AW;
  localparam int SHIFT_A     = 17;
  localparam int SHIFT_B     = 23;

  localparam logic [VALUE_W-1:0] HASH_SALT = 64'h0000_0000_DEAD_BEEF;
  localparam logic [EST_W-1:0]   EST_MAX   = {EST_W{1'b1}};
  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(EXACT_SET_DEPTH);

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_run;
    logic insert;
    logic go_sketch;
    logic row1_wr;
    logic row2_rd;
    logic row2_wr;
    logic out_load;
  } dvc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic overflowed;
    logic scan_done;
    logic hit;
    logic full;
  } dvc_stat_t;

  function automatic logic is_nan(input logic [VALUE_W-1:0] v);
    logic res;
    res = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    return res;
  endfunction

  // Double equality on raw patterns: both zeros match, NaN never matches.
  function automatic logic dbl_equal(input logic [VALUE_W-1:0] a,
                                     input logic [VALUE_W-1:0] b);
    logic res;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/dvc_if.sv
// Request and result channel interfaces of the distinct value counter.
interface dvc_in_if import dvc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [VALUE_W-1:0] value_bits;

  modport source (output valid, output command, output value_bits, input ready);
  modport sink   (input valid, input command, input value_bits, output ready);
endinterface

interface dvc_out_if import dvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EST_W-1:0] distinct_estimate;
  logic             sketch_mode;
  logic             counted_new;

  modport source (output valid, output distinct_estimate, output sketch_mode,
                  output counted_new, input ready);
  modport sink   (input valid, input distinct_estimate, input sketch_mode,
                  input counted_new, output ready);
endinterface

>>> rtl/core/distinct_value_counter.sv
// After acceptance a clear goes straight to emit, an exact-mode add scans the store (one stored
// value read per scan cycle), a Bloom-mode add makes two read-modify-write passes on the bitmap
// and the add that overflows the set does both; a result still waiting holds the next one in emit.
// One request at a time: the next is taken the cycle after a result is loaded, even if it waits.
// Reset is synchronous and active low; it empties the exact store and the bitmap
// at once through the fill count and the per-row valid bits, with no clearing pass.
module distinct_value_counter import dvc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  dvc_in_if.sink   in_chan,
  dvc_out_if.source out_chan
);

  dvc_cmd_t  cmd;
  dvc_stat_t stat;

  dvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dvc_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_command            (in_chan.command),
    .in_value_bits         (in_chan.value_bits),
    .stat                  (stat),
    .out_distinct_estimate (out_chan.distinct_estimate),
    .out_sketch_mode       (out_chan.sketch_mode),
    .out_counted_new       (out_chan.counted_new)
  );

endmodule

>>> rtl/core/dvc_datapath.sv
// Datapath: exact value store with scan compare, Bloom bitmap and estimate counter.
module dvc_datapath import dvc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dvc_cmd_t           cmd,
  input  logic               in_command,
  input  logic [VALUE_W-1:0] in_value_bits,
  output dvc_stat_t          stat,
  output logic [EST_W-1:0]   out_distinct_estimate,
  output logic               out_sketch_mode,
  output logic               out_counted_new
);

  logic [VALUE_W-1:0] exact_mem [EXACT_SET_DEPTH];
  logic [ROW_W-1:0]   filt_mem  [FILTER_ROWS];

  logic               command_r;
  logic [VALUE_W-1:0] value_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FILL_W-1:0]  idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic               hit_r, hit_nxt;
  logic               overflowed_r, overflowed_nxt;
  logic [EST_W-1:0]   est_r, est_nxt;
  logic               raised_r, raised_nxt;
  logic               was1_r;
  logic [FILTER_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [VALUE_W-1:0] exact_rdata_r;
  logic [ROW_W-1:0]   filt_rdata_r;
  logic               filt_rvalid_r;
  logic [EST_W-1:0]   est_out_r;
  logic               mode_out_r;
  logic               new_out_r;

  logic [VALUE_W-1:0] h1, h2;
  logic [ROW_AW-1:0]  row1, row2, rd_row, wr_row;
  logic [BIT_AW-1:0]  bit1, bit2, wr_bit;
  logic [ROW_W-1:0]   base_row, wr_data;
  logic               cur_was, was2, raise2, bump, issue;

  assign h1   = value_r ^ (value_r >> SHIFT_A);
  assign h2   = value_r ^ (value_r >> SHIFT_B) ^ HASH_SALT;
  assign row1 = h1[FILT_AW-1:BIT_AW];
  assign bit1 = h1[BIT_AW-1:0];
  assign row2 = h2[FILT_AW-1:BIT_AW];
  assign bit2 = h2[BIT_AW-1:0];

  assign rd_row   = cmd.row2_rd ? row2 : row1;
  assign wr_row   = cmd.row2_wr ? row2 : row1;
  assign wr_bit   = cmd.row2_wr ? bit2 : bit1;
  assign base_row = filt_rvalid_r ? filt_rdata_r : '0;
  assign wr_data  = base_row | (ROW_W'(1) << wr_bit);
  assign cur_was  = base_row[wr_bit];
  assign was2     = (h1[FILT_AW-1:0] == h2[FILT_AW-1:0]) ? was1_r : cur_was;
  assign raise2   = !was1_r && !was2;
  assign bump     = cmd.insert || (cmd.row2_wr && raise2);
  assign issue    = cmd.scan_run && (idx_r < fill_r);

  always_comb begin
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    overflowed_nxt = overflowed_r;
    est_nxt        = est_r;
    raised_nxt     = raised_r;
    row_valid_nxt  = row_valid_r;
    if (cmd.load) begin
      idx_nxt    = '0;
      pend_nxt   = 1'b0;
      hit_nxt    = 1'b0;
      raised_nxt = 1'b0;
    end
    if (cmd.scan_run) begin
      pend_nxt = issue;
      if (issue) begin
        idx_nxt = idx_r + FILL_W'(1);
      end
      if (pend_r && dbl_equal(exact_rdata_r, value_r)) begin
        hit_nxt = 1'b1;
      end
    end
    if (cmd.insert) begin
      fill_nxt   = fill_r + FILL_W'(1);
      raised_nxt = 1'b1;
    end
    if (cmd.go_sketch) begin
      overflowed_nxt = 1'b1;
    end
    if (cmd.row1_wr || cmd.row2_wr) begin
      row_valid_nxt[wr_row] = 1'b1;
    end
    if (cmd.row2_wr) begin
      raised_nxt = raise2;
    end
    if (bump && (est_r != EST_MAX)) begin
      est_nxt = est_r + EST_W'(1);
    end
    if (cmd.clear) begin
      fill_nxt       = '0;
      overflowed_nxt = 1'b0;
      est_nxt        = '0;
      raised_nxt     = 1'b0;
      row_valid_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      hit_r        <= 1'b0;
      overflowed_r <= 1'b0;
      est_r        <= '0;
      raised_r     <= 1'b0;
      row_valid_r  <= '0;
    end else begin
      fill_r       <= fill_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      hit_r        <= hit_nxt;
      overflowed_r <= overflowed_nxt;
      est_r        <= est_nxt;
      raised_r     <= raised_nxt;
      row_valid_r  <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_command;
      value_r   <= in_value_bits;
    end
    if (cmd.row1_wr) begin
      was1_r <= cur_was;
    end
    if (cmd.out_load) begin
      est_out_r  <= est_r;
      mode_out_r <= overflowed_r;
      new_out_r  <= raised_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      exact_mem[fill_r[EXACT_AW-1:0]] <= value_r;
    end
    exact_rdata_r <= exact_mem[idx_r[EXACT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.row1_wr || cmd.row2_wr) begin
      filt_mem[wr_row] <= wr_data;
    end
    filt_rdata_r  <= filt_mem[rd_row];
    filt_rvalid_r <= row_valid_r[rd_row];
  end

  assign stat.is_clear   = (command_r == CMD_CLEAR);
  assign stat.overflowed = overflowed_r;
  assign stat.scan_done  = hit_r || (!pend_r && (idx_r >= fill_r));
  assign stat.hit        = hit_r;
  assign stat.full       = (fill_r == FILL_FULL);

  assign out_distinct_estimate = est_out_r;
  assign out_sketch_mode       = mode_out_r;
  assign out_counted_new       = new_out_r;

endmodule

>>> rtl/core/dvc_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module dvc_ctrl import dvc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dvc_stat_t stat,
  output dvc_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_H1WR   = 7'b0001000,
    S_H2RD   = 7'b0010000,
    S_H2WR   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } dvc_state_t;

  dvc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_clear) begin
          cmd.clear = 1'b1;
          state_nxt = S_EMIT;
        end else if (stat.overflowed) begin
          state_nxt = S_H1WR;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          if (stat.hit) begin
            state_nxt = S_EMIT;
          end else if (!stat.full) begin
            cmd.insert = 1'b1;
            state_nxt  = S_EMIT;
          end else begin
            cmd.go_sketch = 1'b1;
            state_nxt     = S_H1WR;
          end
        end
      end
      S_H1WR: begin
        cmd.row1_wr = 1'b1;
        state_nxt   = S_H2RD;
      end
      S_H2RD: begin
        cmd.row2_rd = 1'b1;
        state_nxt   = S_H2WR;
      end
      S_H2WR: begin
        cmd.row2_wr = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
